// File: hdl/group_probed_hash_index_defines.svh
// ----------------------------------------------------------------------------
// group_probed_hash_index_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GROUP_PROBED_HASH_INDEX_DEFINES_SVH
`define GROUP_PROBED_HASH_INDEX_DEFINES_SVH

// same-cycle implication
`define GPHI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPHI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gphi_pkg.sv
// ----------------------------------------------------------------------------
// gphi_pkg
// Types and constants of the group probed hash index.
// ----------------------------------------------------------------------------
`default_nettype none

package gphi_pkg;

  localparam logic [7:0]  CTRL_EMPTY = 8'h80;
  localparam logic [7:0]  CTRL_TOMB  = 8'hFE;
  localparam logic [63:0] MIX_K      = 64'h9E3779B97F4A7C15;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LOG2 = 2'd1;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [2:0] MIX_LAST_STEP = 3'd5;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MIX_LO,
    MIX_HI,
    MIX_CROSS
  } mix_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_READ,
    S_CHECK,
    S_REF,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [63:0] key_digest;
    logic [63:0] record_ref;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        inserted;
    logic        previous_valid;
    logic [63:0] previous_ref;
    logic [9:0]  slot_num;
    logic [7:0]  groups_probed;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       mix;
    mix_phase_t mix_phase;
    logic       mix_second;
    logic       probe;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/gphi_ctrl.sv
// ----------------------------------------------------------------------------
// gphi_ctrl
// Sequencer: hash mixing steps, group probe loop, commit and response.
// ----------------------------------------------------------------------------
`default_nettype none

module gphi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  gphi_pkg::sts_t sts,
  output gphi_pkg::cmd_t cmd
);
  import gphi_pkg::*;

  state_t     state, state_next;
  logic [2:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    cmd.mix_phase  = MIX_LO;
    in_stall       = rst || (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix        = 1'b1;
        cmd.mix_second = (step > 3'd2);
        unique case (step)
          3'd0, 3'd3: cmd.mix_phase = MIX_LO;
          3'd1, 3'd4: cmd.mix_phase = MIX_HI;
          default:    cmd.mix_phase = MIX_CROSS;
        endcase
        step_next = step + 3'd1;
        if (step == MIX_LAST_STEP) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.probe = 1'b1;
        if (sts.stop || sts.last) begin
          state_next = S_REF;
        end else begin
          state_next = S_READ;
        end
      end
      S_REF: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/gphi_datapath.sv
// ----------------------------------------------------------------------------
// gphi_datapath
// Hash mixer, lane memories for control bytes and keys, reference memory,
// probe compare, commit logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gphi_datapath #(
  parameter int GROUP_SIZE = 8,
  parameter int SLOT_COUNT = 1024,
  parameter int KEY_BYTES  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gphi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                       cfg_data,
  input  gphi_pkg::in_t                     in_data,
  input  gphi_pkg::cmd_t                    cmd,
  output gphi_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gphi_pkg::out_t                    out_data
);
  import gphi_pkg::*;

  localparam int ROWS     = SLOT_COUNT / GROUP_SIZE;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W   = $clog2(GROUP_SIZE);
  localparam int SLOT_W   = ROW_W + LANE_W;
  localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int MAX_GLOG = $clog2(ROWS + 1) - 1;

  // configuration
  logic [63:0] seed;
  logic [2:0]  glog;

  // request
  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic [3:0]  len_q;
  logic [31:0] tag_q;
  logic [63:0] ref_q;

  // mixer
  logic [63:0] x, acc;
  logic [31:0] mul_a, mul_b, acc_hi_sum;
  logic [63:0] prod, v, mixed;
  logic [6:0]  fp;

  // probe
  logic [ROW_W-1:0]  cur_row, row_mask;
  logic [7:0]        probed, groups;
  logic [2:0]        glog_eff;
  logic [CNT_W-1:0]  cap, limit, live, tombs;
  logic              hit_f, empty_f, tomb_f;
  logic [SLOT_W-1:0] hit_slot, empty_slot, tomb_slot;

  // memories
  logic [ROWS-1:0] row_valid;
  logic            rv_q;
  logic [7:0]      ctrl_rd [GROUP_SIZE];
  logic [63:0]     key_rd  [GROUP_SIZE];
  logic [3:0]      len_rd  [GROUP_SIZE];
  logic [31:0]     tag_rd  [GROUP_SIZE];
  logic [63:0]     refs    [SLOT_COUNT];
  logic [63:0]     ref_rd;

  // compare
  logic              stop_any, stop_hit, tomb_any, tomb_ok;
  logic [LANE_W-1:0] stop_idx, tomb_idx;

  // commit
  logic              wr_ctrl, wr_key, wr_ref;
  logic [7:0]        wr_byte;
  logic [SLOT_W-1:0] wr_slot;
  logic [ROW_W-1:0]  wr_row;
  logic [LANE_W-1:0] wr_lane;
  out_t              res;
  logic [CNT_W-1:0]  live_next, tombs_next;

  logic [3:0]  len_c;
  logic [63:0] key_m;

  always_comb begin
    len_c = (in_data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_data.key_length;
    for (int b = 0; b < 8; b++) begin
      key_m[b*8 +: 8] = (4'(b) < len_c) ? in_data.key_bytes[b*8 +: 8] : 8'h00;
    end
  end

  assign glog_eff = (int'(glog) > MAX_GLOG) ? 3'(MAX_GLOG) : glog;
  assign groups   = 8'd1 << glog_eff;
  assign row_mask = ROW_W'(groups - 8'd1);
  assign cap      = CNT_W'(GROUP_SIZE) << glog_eff;
  assign limit    = cap - (cap >> 3);

  assign mul_a      = (cmd.mix_phase == MIX_HI) ? x[63:32] : x[31:0];
  assign mul_b      = (cmd.mix_phase == MIX_CROSS) ? MIX_K[63:32] : MIX_K[31:0];
  assign prod       = 64'(mul_a) * 64'(mul_b);
  assign acc_hi_sum = acc[63:32] + prod[31:0];
  assign v          = {acc_hi_sum, acc[31:0]};
  assign mixed      = cmd.mix_second ? (v ^ (v >> 29)) : (v ^ (v >> 33));

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      glog <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HASH_SEED) begin
        seed <= cfg_data;
      end else if (cfg_index == CFG_GROUP_LOG2) begin
        glog <= cfg_data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_data.op;
      key_q <= key_m;
      len_q <= len_c;
      tag_q <= in_data.key_digest[31:0];
      ref_q <= in_data.record_ref;
      x     <= in_data.key_digest ^ seed;
    end
    if (cmd.mix) begin
      unique case (cmd.mix_phase)
        MIX_LO:    acc        <= prod;
        MIX_HI:    acc[63:32] <= acc_hi_sum;
        MIX_CROSS: x          <= mixed;
        default:   acc        <= acc;
      endcase
      if (cmd.mix_phase == MIX_CROSS && cmd.mix_second) begin
        fp      <= (mixed[6:0] == 7'd0) ? 7'd1 : mixed[6:0];
        cur_row <= mixed[7 +: ROW_W] & row_mask;
      end
    end
    if (cmd.probe) begin
      cur_row <= (cur_row + ROW_W'(1)) & row_mask;
      if (tomb_ok && !tomb_f) begin
        tomb_slot <= {cur_row, tomb_idx};
      end
      if (stop_any && stop_hit) begin
        hit_slot <= {cur_row, stop_idx};
      end
      if (stop_any && !stop_hit) begin
        empty_slot <= {cur_row, stop_idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_f   <= 1'b0;
      empty_f <= 1'b0;
      tomb_f  <= 1'b0;
      probed  <= '0;
    end else if (cmd.load) begin
      hit_f   <= 1'b0;
      empty_f <= 1'b0;
      tomb_f  <= 1'b0;
      probed  <= '0;
    end else if (cmd.probe) begin
      probed <= probed + 8'd1;
      if (tomb_ok) begin
        tomb_f <= 1'b1;
      end
      if (stop_any) begin
        hit_f   <= stop_hit;
        empty_f <= !stop_hit;
      end
    end
  end

  for (genvar l = 0; l < GROUP_SIZE; l++) begin : g_lane
    logic [7:0]  ctrl_mem [ROWS];
    logic [63:0] key_mem  [ROWS];
    logic [3:0]  len_mem  [ROWS];
    logic [31:0] tag_mem  [ROWS];

    always_ff @(posedge clk) begin
      if (wr_ctrl && (wr_lane == LANE_W'(l) || !row_valid[wr_row])) begin
        ctrl_mem[wr_row] <= (wr_lane == LANE_W'(l)) ? wr_byte : CTRL_EMPTY;
      end
      if (wr_key && wr_lane == LANE_W'(l)) begin
        key_mem[wr_row] <= key_q;
        len_mem[wr_row] <= len_q;
        tag_mem[wr_row] <= tag_q;
      end
      ctrl_rd[l] <= ctrl_mem[cur_row];
      key_rd[l]  <= key_mem[cur_row];
      len_rd[l]  <= len_mem[cur_row];
      tag_rd[l]  <= tag_mem[cur_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cfg_we && cfg_index == CFG_GROUP_LOG2) begin
      row_valid <= '0;
    end else if (wr_ctrl) begin
      row_valid[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rv_q <= row_valid[cur_row];
    if (wr_ref) begin
      refs[wr_slot] <= ref_q;
    end
    ref_rd <= refs[hit_slot];
  end

  always_comb begin
    logic [7:0] c;
    logic       e, t, h;
    stop_any = 1'b0;
    stop_hit = 1'b0;
    stop_idx = '0;
    tomb_any = 1'b0;
    tomb_idx = '0;
    for (int l = GROUP_SIZE - 1; l >= 0; l--) begin
      c = rv_q ? ctrl_rd[l] : CTRL_EMPTY;
      e = (c == CTRL_EMPTY);
      t = (c == CTRL_TOMB);
      h = (c == {1'b0, fp}) && (len_rd[l] == len_q) && (tag_rd[l] == tag_q) &&
          (key_rd[l] == key_q);
      if (e || h) begin
        stop_any = 1'b1;
        stop_hit = h;
        stop_idx = LANE_W'(l);
      end
      if (t) begin
        tomb_any = 1'b1;
        tomb_idx = LANE_W'(l);
      end
    end
    tomb_ok = tomb_any && (!stop_any || tomb_idx < stop_idx);
  end

  assign sts.stop     = stop_any;
  assign sts.last     = ((probed + 8'd1) == groups);
  assign sts.out_busy = out_valid && out_stall;

  always_comb begin
    logic ins;
    ins        = 1'b0;
    wr_ctrl    = 1'b0;
    wr_key     = 1'b0;
    wr_ref     = 1'b0;
    wr_byte    = {1'b0, fp};
    wr_slot    = hit_slot;
    live_next  = live;
    tombs_next = tombs;
    res        = '0;
    res.status = ST_ABSENT;
    res.groups_probed = probed;
    if (hit_f) begin
      res.status         = ST_OK;
      res.previous_valid = 1'b1;
      res.previous_ref   = ref_rd;
      res.slot_num       = 10'(hit_slot);
      if (op_q == OP_INSERT) begin
        wr_ref = cmd.finish;
      end else if (op_q == OP_ERASE) begin
        wr_ctrl    = cmd.finish;
        wr_byte    = CTRL_TOMB;
        live_next  = live - CNT_W'(1);
        tombs_next = tombs + CNT_W'(1);
      end
    end else if (op_q == OP_INSERT) begin
      res.status = ST_FULL;
      if (tomb_f) begin
        ins        = 1'b1;
        wr_slot    = tomb_slot;
        tombs_next = tombs - CNT_W'(1);
      end else if (empty_f && ((live + tombs) < limit)) begin
        ins     = 1'b1;
        wr_slot = empty_slot;
      end
      if (ins) begin
        res.status     = ST_OK;
        res.inserted   = 1'b1;
        res.slot_num   = 10'(wr_slot);
        live_next      = live + CNT_W'(1);
        wr_ctrl        = cmd.finish;
        wr_key         = cmd.finish;
        wr_ref         = cmd.finish;
      end
    end
  end

  assign wr_row  = wr_slot[SLOT_W-1:LANE_W];
  assign wr_lane = wr_slot[LANE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= '0;
      tombs <= '0;
    end else if (cfg_we && cfg_index == CFG_GROUP_LOG2) begin
      live  <= '0;
      tombs <= '0;
    end else if (cmd.finish) begin
      live  <= live_next;
      tombs <= tombs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: hdl/group_probed_hash_index.sv
// ----------------------------------------------------------------------------
// group_probed_hash_index
// A new request is stalled until the previous one has finished and its result is registered.
// Six mixer steps on one 32x32 multiplier, then for each group probed (1..128 groups)
// a group memory read and a compare, until a hit, an empty slot or the last group.
// Reset: synchronous; table empty, counts, flags and configuration zero, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module group_probed_hash_index #(
  parameter int GROUP_SIZE = 8,
  parameter int SLOT_COUNT = 1024,
  parameter int KEY_BYTES  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gphi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gphi_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gphi_pkg::out_t                 out_data
);
  import gphi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = !rst;

  gphi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gphi_datapath #(
    .GROUP_SIZE (GROUP_SIZE),
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BYTES  (KEY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/gphi_checker.sv
// ----------------------------------------------------------------------------
// gphi_checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "group_probed_hash_index_defines.svh"

module gphi_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input gphi_pkg::out_t out_data
);
  import gphi_pkg::*;

  `GPHI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `GPHI_ASSERT_IMPL(a_miss_slot, clk, rst, out_valid && out_data.status != ST_OK, out_data.slot_num == 10'd0 && !out_data.inserted, "slot or insert on failed transaction")
  `GPHI_ASSERT_IMPL(a_ins_fresh, clk, rst, out_valid && out_data.inserted, out_data.status == ST_OK && !out_data.previous_valid, "insert reported with previous entry")
  `GPHI_ASSERT_IMPL(a_prev_zero, clk, rst, out_valid && !out_data.previous_valid, out_data.previous_ref == 64'd0 && out_data.groups_probed != 8'd0, "bad previous ref or probe count")

endmodule

bind group_probed_hash_index gphi_checker u_gphi_checker (.*);

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for group_probed_hash_index. A scoreboard class keeps
// its own copy of the control bytes, keys and counts, predicts each lookup,
// insert and erase, and compares every result with the oldest prediction.
// The table is resized and reseeded between phases, and both sides stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

import gphi_pkg::*;

class hash_index_scoreboard;
  localparam int SLOTS = 1024;
  localparam int GSIZE = 8;

  logic [63:0] seed;
  logic [2:0]  glog2;
  logic [7:0]  ctrl[SLOTS];
  logic [63:0] keys[SLOTS];
  logic [3:0]  lens[SLOTS];
  logic [31:0] tags[SLOTS];
  logic [63:0] refs[SLOTS];
  int unsigned live;
  int unsigned tombs;
  out_t        pending[$];
  int          errors;

  function new();
    seed   = '0;
    glog2  = '0;
    errors = 0;
    clear_table();
  endfunction

  function void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      ctrl[i] = CTRL_EMPTY;
      keys[i] = '0;
      lens[i] = '0;
      tags[i] = '0;
      refs[i] = '0;
    end
    live  = 0;
    tombs = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    if (idx == CFG_HASH_SEED) begin
      seed = data;
    end else if (idx == CFG_GROUP_LOG2) begin
      glog2 = data[2:0];
      clear_table();
    end
  endfunction

  function int unsigned group_count();
    int unsigned g;
    g = 1 << glog2;
    while (g > 1 && g * GSIZE > SLOTS) g = g >> 1;
    return g;
  endfunction

  function logic [63:0] scramble(logic [63:0] h);
    h = h ^ seed;
    h = h * MIX_K;
    h = h ^ (h >> 33);
    h = h * MIX_K;
    h = h ^ (h >> 29);
    return h;
  endfunction

  static function logic [63:0] byte_mask(int unsigned len);
    return len >= 8 ? '1 : (64'd1 << (len * 8)) - 64'd1;
  endfunction

  function void note_request(in_t r);
    int unsigned len, groups, cap, fp, gs, s, hit_slot, empty_slot, tomb_slot, probed;
    logic [63:0] key, h;
    logic [31:0] tag;
    bit          hit, found_empty, have_tomb;
    out_t        e;
    len = r.key_length;
    if (len > 8) len = 8;
    key = r.key_bytes & byte_mask(len);
    tag = r.key_digest[31:0];
    groups = group_count();
    cap = groups * GSIZE;
    h = scramble(r.key_digest);
    fp = h[6:0];
    if (fp == 0) fp = 1;
    gs = 32'((h >> 7) & 64'(groups - 1)) * GSIZE;
    hit = 0; found_empty = 0; have_tomb = 0;
    hit_slot = 0; empty_slot = 0; tomb_slot = 0; probed = groups;
    for (int p = 0; p < groups && !hit && !found_empty; p++) begin
      for (int o = 0; o < GSIZE; o++) begin
        s = gs + o;
        if (ctrl[s] == CTRL_EMPTY) begin
          found_empty = 1;
          empty_slot = s;
          probed = p + 1;
          break;
        end
        if (ctrl[s] == CTRL_TOMB && !have_tomb) begin
          have_tomb = 1;
          tomb_slot = s;
        end
        if (ctrl[s] == fp && lens[s] == len && tags[s] == tag &&
            ((keys[s] ^ key) & byte_mask(len)) == 0) begin
          hit = 1;
          hit_slot = s;
          probed = p + 1;
          break;
        end
      end
      gs = gs + GSIZE;
      if (gs >= cap) gs = gs - cap;
    end
    e = '0;
    e.status = ST_ABSENT;
    if (hit) begin
      e.status = ST_OK;
      e.previous_valid = 1'b1;
      e.previous_ref = refs[hit_slot];
      e.slot_num = 10'(hit_slot);
      if (r.op == OP_INSERT) begin
        refs[hit_slot] = r.record_ref;
      end else if (r.op == OP_ERASE) begin
        ctrl[hit_slot] = CTRL_TOMB;
        live--;
        tombs++;
      end
    end else if (r.op == OP_INSERT) begin
      e.status = ST_FULL;
      s = 0;
      if (have_tomb) begin
        s = tomb_slot;
        e.status = ST_OK;
        tombs--;
      end else if (found_empty && live + tombs < cap - cap / 8) begin
        s = empty_slot;
        e.status = ST_OK;
      end
      if (e.status == ST_OK) begin
        ctrl[s] = 8'(fp);
        keys[s] = key;
        lens[s] = 4'(len);
        tags[s] = tag;
        refs[s] = r.record_ref;
        live++;
        e.inserted = 1'b1;
        e.slot_num = 10'(s);
      end
    end
    e.groups_probed = 8'(probed);
    pending.insert(pending.size(), e);
  endfunction

  function void report(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 60)
      $display("%0t mismatch %s: expected %h actual %h", $time, field, want, got);
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 60) $display("%0t unexpected result %h", $time, got);
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) report("status", want.status, got.status);
    if (got.inserted !== want.inserted) report("inserted", want.inserted, got.inserted);
    if (got.previous_valid !== want.previous_valid)
      report("previous_valid", want.previous_valid, got.previous_valid);
    if (got.previous_ref !== want.previous_ref)
      report("previous_ref", want.previous_ref, got.previous_ref);
    if (got.slot_num !== want.slot_num)
      report("slot_num", want.slot_num, got.slot_num);
    if (got.groups_probed !== want.groups_probed)
      report("groups_probed", want.groups_probed, got.groups_probed);
  endfunction
endclass

typedef struct {
  logic [63:0] key;
  logic [3:0]  len;
  logic [63:0] hash;
} key_entry_t;

module tb;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 300;
  localparam int HOLD_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;

  hash_index_scoreboard table_model = new();
  key_entry_t           key_pool[$];
  int                   send_gap_pct = 0;
  int                   recv_stall_pct = 0;
  int                   hold_request = 0;
  int                   hold_taken = 0;
  int                   hold_left = 0;
  int unsigned          cycles = 0;

  group_probed_hash_index dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) table_model.write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) table_model.note_request(in_data);
      if (out_valid && !out_stall) table_model.check_result(out_data);
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_request != hold_taken) begin
      hold_taken = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(in_t x);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic request(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                         logic [63:0] hash, logic [63:0] ref_val);
    in_t x;
    x.op = op;
    x.key_bytes = key;
    x.key_length = len;
    x.key_digest = hash;
    x.record_ref = ref_val;
    send(x);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (table_model.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return OP_INSERT;
    if (r < 72) return OP_FIND;
    if (r < 95) return OP_ERASE;
    return OP_SPARE;
  endfunction

  task automatic build_pool(int n);
    key_entry_t k;
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      k.key = rand64();
      k.len = 4'($urandom_range(0, 15));
      k.hash = rand64();
      // some entries collide with an earlier one in hash or key
      if (i > 0 && $urandom_range(9) < 2) begin
        k.hash = key_pool[$urandom_range(i - 1)].hash;
      end else if (i > 0 && $urandom_range(9) < 1) begin
        k = key_pool[$urandom_range(i - 1)];
        k.len = 4'($urandom_range(0, 15));
      end
      key_pool.insert(key_pool.size(), k);
    end
  endtask

  task automatic random_requests(int n);
    key_entry_t  k;
    logic [63:0] m;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 9) begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
        m = table_model.byte_mask(k.len > 8 ? 8 : k.len);
        k.key = (k.key & m) | (rand64() & ~m);
      end else begin
        k.key = rand64();
        k.len = 4'($urandom_range(0, 15));
        k.hash = rand64();
      end
      request(pick_op(), k.key, k.len, k.hash, rand64());
    end
  endtask

  task automatic run_phase(logic [63:0] seed, logic [2:0] log2, int items, int pool);
    drain();
    write_reg(CFG_HASH_SEED, seed);
    write_reg(CFG_GROUP_LOG2, {61'(rand64()), log2});
    build_pool(pool);
    random_requests(items);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default 8-slot table, seed zero
    send_gap_pct = 15;
    recv_stall_pct = 88;
    request(OP_FIND, 64'h0, 4'd0, 64'h0, 64'h0);
    request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, 64'h0, 64'h1111);
    request(OP_INSERT, '1, 4'd8, '1, '1);
    request(OP_INSERT, 64'h0123_4567_89AB_CDEF, 4'd15, 64'h5555_AAAA_5555_AAAA, 64'h22);
    request(OP_FIND, 64'h0, 4'd0, 64'h0, 64'h0);
    request(OP_FIND, '1, 4'd8, '1, 64'h0);
    request(OP_SPARE, 64'h0123_4567_89AB_CDEF, 4'd8, 64'h5555_AAAA_5555_AAAA, 64'h0);
    request(OP_INSERT, '1, 4'd8, '1, 64'h3333);
    request(OP_FIND, 64'h7FFF_FFFF_FFFF_FFFF, 4'd8, '1, 64'h0);
    request(OP_FIND, '1, 4'd7, '1, 64'h0);
    request(OP_ERASE, '1, 4'd8, '1, 64'h0);
    request(OP_ERASE, '1, 4'd8, '1, 64'h0);
    request(OP_FIND, '1, 4'd8, '1, 64'h0);
    request(OP_INSERT, 64'h42, 4'd1, 64'h8000_0000_0000_0001, 64'h44);
    for (int i = 0; i < 8; i++)
      request(OP_INSERT, 64'h100 + i, 4'd2, 64'hC0DE_0000 + i, 64'h500 + i);
    request(OP_ERASE, 64'h42, 4'd1, 64'h8000_0000_0000_0001, 64'h0);
    request(OP_INSERT, 64'h77, 4'd1, 64'h1234, 64'h77);

    run_phase(rand64(), 3'd0, 150, 12);
    run_phase('1, 3'd3, 200, 80);

    // seed change keeps the table
    drain();
    write_reg(CFG_HASH_SEED, rand64());
    random_requests(60);

    send_gap_pct = 88;
    recv_stall_pct = 15;
    run_phase(rand64(), 3'd1, 180, 24);
    run_phase(64'h0, 3'd7, 120, 300);

    // long receiver hold-off while requests keep coming
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_request = hold_request + 1;
    random_requests(40);

    run_phase(rand64(), 3'd2, 280, 40);

    drain();
    if (table_model.errors == 0 && table_model.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
